>>> rtl/pfgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfgb_pkg;

  localparam int GLYPH_BYTES_DEF     = 4096;
  localparam int TABLE_ENTRIES_DEF   = 256;
  localparam int MAX_GLYPH_WIDTH_DEF = 32;
  localparam int MAX_FONT_HEIGHT_DEF = 32;

  localparam logic [2:0] OP_LOAD_INDEX  = 3'd0;
  localparam logic [2:0] OP_LOAD_OFFSET = 3'd1;
  localparam logic [2:0] OP_LOAD_WIDTH  = 3'd2;
  localparam logic [2:0] OP_LOAD_GLYPH  = 3'd3;
  localparam logic [2:0] OP_SET_POS     = 3'd4;
  localparam logic [2:0] OP_CHAR        = 3'd5;
  localparam logic [2:0] OP_SPARE_LO    = 3'd6;
  localparam logic [2:0] OP_SPARE_HI    = 3'd7;

  localparam logic [2:0] REG_SCREEN_WIDTH = 3'd0;
  localparam logic [2:0] REG_FONT_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_DATA_BITS    = 3'd2;
  localparam logic [2:0] REG_FG_COLOR     = 3'd3;
  localparam logic [2:0] REG_BG_COLOR     = 3'd4;
  localparam logic [2:0] REG_FG_ENABLE    = 3'd5;
  localparam logic [2:0] REG_BG_ENABLE    = 3'd6;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_LOW     = 8'd32;
  localparam logic [7:0] CODE_HIGH    = 8'd132;
  localparam logic [7:0] CODE_SUBST   = 8'd180;
  localparam logic [2:0] LATER_TOP_BIT = 3'd7;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] table_address;
    logic [11:0] table_value;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic [23:0] row_address;
    logic [31:0] fg_mask;
    logic [31:0] bg_mask;
    logic [5:0]  row_width;
    logic [31:0] fg_value;
    logic [31:0] bg_value;
    logic        last_row;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/pfgb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pfgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, read one registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/proportional_font_glyph_blitter.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake                  Payload
// in_      input      in_valid / in_ready        pfgb_pkg::in_item_t
// out_     output     out_valid / out_ready      pfgb_pkg::out_item_t
// cfg_     input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Loads, set position and newline are done in ST_IDLE. A character goes through
// table lookup (ST_IDX to ST_TABW), then per row an address-multiply state
// (ST_ROWA), one glyph pixel per cycle through the shared bit walker, a wait
// state (ST_BYTEW) whenever a new glyph byte is needed inside a row, then ST_EMIT
// to hand the row to the output register; a zero width or height skips the rows.
// Sync active-low reset sets control and config defaults; stores are not cleared.
// Output stall holds ST_EMIT; input is taken only when idle with no row pending.
module proportional_font_glyph_blitter #(
  parameter int GLYPH_BYTES     = pfgb_pkg::GLYPH_BYTES_DEF,
  parameter int TABLE_ENTRIES   = pfgb_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_GLYPH_WIDTH = pfgb_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int MAX_FONT_HEIGHT = pfgb_pkg::MAX_FONT_HEIGHT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pfgb_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pfgb_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int TAW = $clog2(TABLE_ENTRIES);
  localparam int GAW = $clog2(GLYPH_BYTES);
  localparam int WCAP = (MAX_GLYPH_WIDTH < 32) ? MAX_GLYPH_WIDTH : 32;
  localparam int HCAP = (MAX_FONT_HEIGHT < 32) ? MAX_FONT_HEIGHT : 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_IDX, ST_IDXW, ST_TAB, ST_TABW, ST_ROWA, ST_WALK, ST_BYTEW, ST_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [11:0] screen_width_r;
  logic [5:0]  font_height_r;
  logic [3:0]  data_bits_r;
  logic [31:0] fg_color_r, bg_color_r;
  logic        fg_enable_r, bg_enable_r;

  logic [11:0] cursor_x_r, cursor_y_r, line_start_x_r;

  // per-character working registers
  logic           code_ok_r;
  logic [7:0]     gi_r;
  logic [5:0]     w_r;
  logic [5:0]     rows_r;
  logic [5:0]     row_r;
  logic [5:0]     col_r;
  logic [2:0]     bit_r;
  logic [GAW-1:0] bytepos_r;
  logic [31:0]    fgm_r, bgm_r;
  logic [23:0]    ra_r;
  logic           out_valid_r;
  pfgb_pkg::out_item_t out_r;

  // store ports
  logic           idx_we, off_we, wid_we, gly_we;
  logic [TAW-1:0] tab_raddr;
  logic [7:0]     idx_rd;
  logic [11:0]    off_rd;
  logic [5:0]     wid_rd;
  logic [7:0]     gly_rd;
  logic [7:0]     code_m;
  logic           accept;
  logic           gi_ok;
  logic           emit_go;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  assign idx_we = accept && in_data.operation == pfgb_pkg::OP_LOAD_INDEX
                  && {4'd0, in_data.table_address} < 16'(TABLE_ENTRIES);
  assign off_we = accept && in_data.operation == pfgb_pkg::OP_LOAD_OFFSET
                  && {4'd0, in_data.table_address} < 16'(TABLE_ENTRIES);
  assign wid_we = accept && in_data.operation == pfgb_pkg::OP_LOAD_WIDTH
                  && {4'd0, in_data.table_address} < 16'(TABLE_ENTRIES);
  assign gly_we = accept && in_data.operation == pfgb_pkg::OP_LOAD_GLYPH
                  && {5'd0, in_data.table_address} < 17'(GLYPH_BYTES);

  // substitute codes outside the range CODE_LOW to CODE_HIGH
  always_comb begin
    code_m = in_data.char_code;
    if (code_m < pfgb_pkg::CODE_LOW || code_m > pfgb_pkg::CODE_HIGH) begin
      code_m = pfgb_pkg::CODE_SUBST;
    end
  end

  assign gi_ok = {1'b0, gi_r} < 9'(TABLE_ENTRIES);
  assign tab_raddr = (state_r == ST_IDLE) ? TAW'(code_m) : TAW'(gi_r);

  pfgb_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_idx (
    .clk(clk), .we(idx_we), .waddr(in_data.table_address[TAW-1:0]),
    .wdata(in_data.table_value[7:0]), .raddr(tab_raddr), .rdata(idx_rd));
  pfgb_ram #(.WIDTH(12), .DEPTH(TABLE_ENTRIES)) u_off (
    .clk(clk), .we(off_we), .waddr(in_data.table_address[TAW-1:0]),
    .wdata(in_data.table_value), .raddr(tab_raddr), .rdata(off_rd));
  pfgb_ram #(.WIDTH(6), .DEPTH(TABLE_ENTRIES)) u_wid (
    .clk(clk), .we(wid_we), .waddr(in_data.table_address[TAW-1:0]),
    .wdata(in_data.table_value[5:0]), .raddr(tab_raddr), .rdata(wid_rd));

  logic [GAW-1:0] gly_waddr;
  assign gly_waddr = GAW'(in_data.table_address);
  pfgb_ram #(.WIDTH(8), .DEPTH(GLYPH_BYTES)) u_gly (
    .clk(clk), .we(gly_we), .waddr(gly_waddr),
    .wdata(in_data.table_value[7:0]), .raddr(bytepos_r), .rdata(gly_rd));

  // bit walker step values
  logic        cur_bit;
  logic [2:0]  top_bit;
  logic [5:0]  w_sat, rows_sat;
  logic [12:0] ysum;
  logic [24:0] ra_prod;
  logic [23:0] ra_calc;
  assign cur_bit = gly_rd[bit_r];
  always_comb begin
    top_bit = (data_bits_r == 4'd0) ? 3'd0 :
              (data_bits_r > 4'd8) ? 3'd7 : 3'(data_bits_r - 4'd1);
    w_sat = (gi_ok && wid_rd > 6'(WCAP)) ? 6'(WCAP) : (gi_ok ? wid_rd : 6'd0);
    rows_sat = (font_height_r > 6'(HCAP)) ? 6'(HCAP) : font_height_r;
    ysum = {1'b0, cursor_y_r} + {7'd0, row_r};
    ra_prod = {12'd0, ysum} * {13'd0, screen_width_r};
    ra_calc = ra_prod[23:0] + {12'd0, cursor_x_r};
  end

  // sequencer and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      screen_width_r <= 12'd640;
      font_height_r  <= 6'd14;
      data_bits_r    <= 4'd8;
      fg_color_r     <= '0;
      bg_color_r     <= '0;
      fg_enable_r    <= 1'b1;
      bg_enable_r    <= 1'b0;
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      line_start_x_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pfgb_pkg::REG_SCREEN_WIDTH: screen_width_r <= cfg_data[11:0];
          pfgb_pkg::REG_FONT_HEIGHT:  font_height_r  <= cfg_data[5:0];
          pfgb_pkg::REG_DATA_BITS:    data_bits_r    <= cfg_data[3:0];
          pfgb_pkg::REG_FG_COLOR:     fg_color_r     <= cfg_data;
          pfgb_pkg::REG_BG_COLOR:     bg_color_r     <= cfg_data;
          pfgb_pkg::REG_FG_ENABLE:    fg_enable_r    <= cfg_data[0];
          pfgb_pkg::REG_BG_ENABLE:    bg_enable_r    <= cfg_data[0];
          default: ;
        endcase
      end
      // load a new row or drop the taken one
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.operation == pfgb_pkg::OP_SET_POS) begin
              cursor_x_r     <= in_data.pos_x;
              line_start_x_r <= in_data.pos_x;
              cursor_y_r     <= in_data.pos_y;
            end else if (in_data.operation == pfgb_pkg::OP_CHAR) begin
              if (in_data.char_code == pfgb_pkg::CODE_NEWLINE) begin
                cursor_x_r <= line_start_x_r;
                cursor_y_r <= cursor_y_r + 12'(font_height_r);
              end else begin
                code_ok_r <= ({1'b0, code_m} < 9'(TABLE_ENTRIES));
                state_r   <= ST_IDX;
              end
            end
          end
        end
        ST_IDX: begin
          // index read was issued at the accepting edge
          gi_r    <= code_ok_r ? idx_rd : 8'd0;
          state_r <= ST_IDXW;
        end
        ST_IDXW: state_r <= ST_TAB;
        ST_TAB: state_r <= ST_TABW;
        ST_TABW: begin
          w_r       <= w_sat;
          rows_r    <= rows_sat;
          row_r     <= '0;
          bit_r     <= top_bit;
          bytepos_r <= gi_ok ? GAW'(off_rd) : '0;
          if (w_sat == 6'd0 || rows_sat == 6'd0) begin
            cursor_x_r <= cursor_x_r + 12'(w_sat);
            state_r    <= ST_IDLE;
          end else begin
            state_r <= ST_ROWA;
          end
        end
        ST_ROWA: begin
          // glyph byte read settles during this cycle
          ra_r    <= ra_calc;
          col_r   <= '0;
          fgm_r   <= '0;
          bgm_r   <= '0;
          state_r <= ST_WALK;
        end
        ST_WALK: begin
          // one pixel per cycle; a byte change waits in ST_BYTEW for the read
          if (cur_bit && fg_enable_r) fgm_r[col_r[4:0]] <= 1'b1;
          if (!cur_bit && bg_enable_r) bgm_r[col_r[4:0]] <= 1'b1;
          if (bit_r == 3'd0) begin
            bit_r     <= pfgb_pkg::LATER_TOP_BIT;
            bytepos_r <= bytepos_r + GAW'(1);
          end else begin
            bit_r <= bit_r - 3'd1;
          end
          col_r <= col_r + 6'd1;
          if (col_r + 6'd1 == w_r) begin
            state_r <= ST_EMIT;
          end else if (bit_r == 3'd0) begin
            state_r <= ST_BYTEW;
          end
        end
        // hold the partial row while the next byte is read
        ST_BYTEW: state_r <= ST_WALK;
        ST_EMIT: begin
          if (emit_go) begin
            out_r.row_address <= ra_r;
            out_r.fg_mask     <= fgm_r;
            out_r.bg_mask     <= bgm_r;
            out_r.row_width   <= w_r;
            out_r.fg_value    <= fg_color_r;
            out_r.bg_value    <= bg_color_r;
            out_r.last_row    <= (row_r + 6'd1 == rows_r);
            row_r             <= row_r + 6'd1;
            if (row_r + 6'd1 == rows_r) begin
              cursor_x_r <= cursor_x_r + 12'(w_r);
              state_r    <= ST_IDLE;
            end else begin
              state_r <= ST_ROWA;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("accepted while busy");
  a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (col_r < w_r)) else $error("column overrun");
  a_out_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.row_width != 6'd0)) else $error("zero width row");

endmodule
`default_nettype wire
